// File: hdl/rrts_pkg.sv
package rrts_pkg;

   localparam int MAX_TASKS_DEF = 16;

   localparam int ID_W      = 4;
   localparam int BURST_W   = 16;
   localparam int ELAPSED_W = 8;
   localparam int OUTCOME_W = 2;
   localparam int QUANTUM_W = 16;
   localparam int SLICE_W   = 17;
   localparam int TICK_W    = 32;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd10;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [OUTCOME_W-1:0] OUTCOME_YIELD     = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_TERMINATE = 2'd2;

   localparam logic       FROM_VALID = 1'b0;
   localparam logic       FROM_NONE  = 1'b1;
   localparam logic [1:0] TO_VALID   = 2'd0;
   localparam logic [1:0] TO_DONE    = 2'd2;

   typedef enum logic [2:0] {
      EV_YIELDED,
      EV_COMPLETED,
      EV_STARTED,
      EV_EXPIRED,
      EV_REJECTED
   } event_type;

   typedef struct packed {
      logic [1:0]        to_kind;
      logic [ID_W-1:0]   to_task;
      logic              from_kind;
      logic [ID_W-1:0]   from_task;
      logic [TICK_W-1:0] tick_number;
      event_type         event_kind;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_TICK,
      ST_WAIT,
      ST_RUN,
      ST_OUT0,
      ST_OUT1
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic add;
      logic tick;
      logic run;
      logic load0;
      logic load1;
   } cmd_type;

   typedef struct packed {
      logic add_reject;
      logic elapsed_zero;
      logic cpu_busy;
      logic fifo_empty;
      logic run_emits;
      logic two_results;
      logic out_free;
   } status_type;

endpackage

// File: hdl/rrts_ctrl.sv
module rrts_ctrl
   import rrts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = (req_tuser == REQ_TICK) ? ST_TICK : ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = status.add_reject ? ST_OUT0 : ST_IDLE;
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            if (status.elapsed_zero || (!status.cpu_busy && status.fifo_empty)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.run  = 1'b1;
            state_in = status.run_emits ? ST_OUT0 : ST_IDLE;
         end
         ST_OUT0: begin
            if (status.out_free) begin
               cmd.load0 = 1'b1;
               state_in  = status.two_results ? ST_OUT1 : ST_IDLE;
            end
         end
         ST_OUT1: begin
            if (status.out_free) begin
               cmd.load1 = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/rrts_dp.sv
module rrts_dp
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  logic [QUANTUM_W-1:0]  csr_data,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int PTR_W   = $clog2(MAX_TASKS);
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int BDEPTH  = 1 << ID_W;

   logic [ID_W-1:0]      fifo_mem [MAX_TASKS];
   logic [BURST_W-1:0]   burst_mem [BDEPTH];

   logic [ID_W-1:0]      id_ff;
   logic [BURST_W-1:0]   burst_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [OUTCOME_W-1:0] outcome_ff;
   logic [QUANTUM_W-1:0] quantum_ff;

   logic [PTR_W-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ID_W-1:0]      running_id_ff, running_id_in;
   logic                 running_valid_ff, running_valid_in;
   logic                 needs_run_ff, needs_run_in;
   logic [SLICE_W-1:0]   slice_ff, slice_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [ID_W-1:0]      fifo_rd_ff;
   logic [BURST_W-1:0]   burst_rd_ff;
   result_type           pend0_ff, pend0_in, pend1_ff, pend1_in;
   logic                 two_ff, two_in;
   logic                 rsp_valid_ff;
   result_type           rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 fifo_we;
   logic [ID_W-1:0]      fifo_wd;
   logic                 burst_we;
   logic [ID_W-1:0]      burst_wa;
   logic [BURST_W-1:0]   burst_wd;

   logic [PTR_W-1:0]     head_nxt, tail_nxt;
   logic                 full, empty, add_reject;
   logic                 do_yield, do_term, do_done, do_expire;
   logic [BURST_W-1:0]   elapsed_ext, b_new;
   logic [SLICE_W:0]     slice_sum;
   logic [SLICE_W-1:0]   slice_sat;
   logic [ID_W-1:0]      cur, yield_next;
   logic                 out_free;

   assign head_nxt = (head_ff == PTR_W'(MAX_TASKS - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_nxt = (tail_ff == PTR_W'(MAX_TASKS - 1)) ? '0 : tail_ff + PTR_W'(1);
   assign full       = (count_ff == CNT_W'(MAX_TASKS));
   assign empty      = (count_ff == '0);
   assign add_reject = full || (int'(id_ff) >= MAX_TASKS);

   assign cur         = running_id_ff;
   assign do_yield    = needs_run_ff && (outcome_ff == OUTCOME_YIELD);
   assign do_term     = needs_run_ff && (outcome_ff == OUTCOME_TERMINATE);
   assign elapsed_ext = BURST_W'(elapsed_ff);
   assign b_new       = (burst_rd_ff > elapsed_ext) ? burst_rd_ff - elapsed_ext : '0;
   assign slice_sum   = {1'b0, slice_ff} + (SLICE_W + 1)'(elapsed_ff);
   assign slice_sat   = slice_sum[SLICE_W] ? '1 : slice_sum[SLICE_W-1:0];
   assign do_done     = do_term || (!do_yield && (b_new == '0));
   assign do_expire   = !do_yield && !do_done && (slice_sat >= SLICE_W'(quantum_ff));
   assign yield_next  = empty ? cur : fifo_rd_ff;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      status.add_reject   = add_reject;
      status.elapsed_zero = (elapsed_ff == '0);
      status.cpu_busy     = running_valid_ff;
      status.fifo_empty   = empty;
      status.run_emits    = do_yield || do_done || do_expire;
      status.two_results  = two_ff;
      status.out_free     = out_free;
   end

   always_comb begin
      head_in          = head_ff;
      tail_in          = tail_ff;
      count_in         = count_ff;
      running_id_in    = running_id_ff;
      running_valid_in = running_valid_ff;
      needs_run_in     = needs_run_ff;
      slice_in         = slice_ff;
      tick_in          = tick_ff;
      pend0_in         = pend0_ff;
      pend1_in         = pend1_ff;
      two_in           = two_ff;
      fifo_we          = 1'b0;
      fifo_wd          = id_ff;
      burst_we         = 1'b0;
      burst_wa         = id_ff;
      burst_wd         = burst_ff;

      if (cmd.add) begin
         two_in = 1'b0;
         if (add_reject) begin
            pend0_in = '{to_kind: TO_VALID, to_task: id_ff, from_kind: FROM_NONE,
                         from_task: '0, tick_number: tick_ff, event_kind: EV_REJECTED};
         end else begin
            burst_we = 1'b1;
            fifo_we  = 1'b1;
            tail_in  = tail_nxt;
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.tick && (elapsed_ff != '0)) begin
         tick_in = tick_ff + TICK_W'(1);
         if (!running_valid_ff && !empty) begin
            running_id_in    = fifo_rd_ff;
            running_valid_in = 1'b1;
            needs_run_in     = 1'b1;
            head_in          = head_nxt;
            count_in         = count_ff - CNT_W'(1);
         end
      end

      if (cmd.run) begin
         needs_run_in = 1'b0;
         two_in       = 1'b0;
         if (do_yield) begin
            if (!full) begin
               fifo_we = 1'b1;
               fifo_wd = cur;
               tail_in = tail_nxt;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
            head_in       = head_nxt;
            running_id_in = yield_next;
            needs_run_in  = 1'b1;
            slice_in      = '0;
            pend0_in = '{to_kind: TO_VALID, to_task: yield_next, from_kind: FROM_VALID,
                         from_task: cur, tick_number: tick_ff, event_kind: EV_YIELDED};
         end else begin
            if (!do_term) begin
               burst_we = 1'b1;
               burst_wa = cur;
               burst_wd = b_new;
            end
            slice_in = slice_sat;
            if (do_done) begin
               slice_in = '0;
               pend0_in = '{to_kind: TO_DONE, to_task: '0, from_kind: FROM_VALID,
                            from_task: cur, tick_number: tick_ff, event_kind: EV_COMPLETED};
               if (!empty) begin
                  running_id_in = fifo_rd_ff;
                  head_in       = head_nxt;
                  count_in      = count_ff - CNT_W'(1);
                  needs_run_in  = 1'b1;
                  two_in        = 1'b1;
                  pend1_in = '{to_kind: TO_VALID, to_task: fifo_rd_ff, from_kind: FROM_NONE,
                               from_task: '0, tick_number: tick_ff, event_kind: EV_STARTED};
               end else begin
                  running_valid_in = 1'b0;
               end
            end else if (do_expire) begin
               slice_in     = '0;
               needs_run_in = 1'b1;
               if (!empty) begin
                  running_id_in = fifo_rd_ff;
                  head_in       = head_nxt;
                  fifo_we       = 1'b1;
                  fifo_wd       = cur;
                  tail_in       = tail_nxt;
               end
               pend0_in = '{to_kind: TO_VALID, to_task: yield_next, from_kind: FROM_VALID,
                            from_task: cur, tick_number: tick_ff, event_kind: EV_EXPIRED};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[tail_ff] <= fifo_wd;
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (burst_we) begin
         burst_mem[burst_wa] <= burst_wd;
      end
      burst_rd_ff <= burst_mem[running_id_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         id_ff      <= req_tdata[ID_W-1:0];
         burst_ff   <= req_tdata[ID_W +: BURST_W];
         elapsed_ff <= req_tdata[ID_W + BURST_W +: ELAPSED_W];
         outcome_ff <= req_tdata[ID_W + BURST_W + ELAPSED_W +: OUTCOME_W];
      end
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
      if (cmd.load0) begin
         rsp_data_ff <= pend0_ff;
         rsp_last_ff <= !two_ff;
      end else if (cmd.load1) begin
         rsp_data_ff <= pend1_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff       <= QUANTUM_RST;
         head_ff          <= '0;
         tail_ff          <= '0;
         count_ff         <= '0;
         running_id_ff    <= '0;
         running_valid_ff <= 1'b0;
         needs_run_ff     <= 1'b0;
         slice_ff         <= '0;
         tick_ff          <= '0;
         two_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            quantum_ff <= csr_data;
         end
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         count_ff         <= count_in;
         running_id_ff    <= running_id_in;
         running_valid_ff <= running_valid_in;
         needs_run_ff     <= needs_run_in;
         slice_ff         <= slice_in;
         tick_ff          <= tick_in;
         two_ff           <= two_in;
         if (cmd.load0 || cmd.load1) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(result_type))'(0), rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hdl/round_robin_time_slice_scheduler.sv
// Round-robin scheduler with a time quantum and a FIFO ready queue of task ids.
// req channel: one transaction per add (tuser 0) or tick (tuser 1) request.
// rsp channel: zero, one or two event records per request, tlast on the final
// one. csr channel: writes the time quantum; always ready, use only when idle.
// A rejected add gives one record, a tick zero, one or two, and a second
// record follows the first. One request is in flight at a time; the next is
// taken once the current one is done and its last record, if any, sits in
// the output register. An add goes through the ADD state (and OUT0 when
// rejected); a tick goes through TICK and, unless ignored or the CPU stays
// idle, through WAIT and RUN, then OUT0 and OUT1 for its records, the wait
// state covering the registered reads of the ready queue and burst table.
// Reset empties the queue, idles the CPU, clears the tick count and loads a
// quantum of 10. The queue and burst table hold stale data until written.
// A stalled receiver holds the output record; requests are then held off
// once a further record is waiting.
module round_robin_time_slice_scheduler
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // task_id[3:0], burst_time[19:4], elapsed_ticks[27:20], run_outcome[29:28]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // event_kind[2:0], tick_number[34:3], from_task[38:35], from_kind[39],
   // to_task[43:40], to_kind[45:44]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [QUANTUM_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrts_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_started_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == EV_STARTED) |-> rsp_tlast)
      else $error("start record is not the final record");

   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == EV_REJECTED) |-> rsp_tdata[39] && rsp_tlast)
      else $error("malformed add_rejected record");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(status.fifo_empty && status.add_reject && !status.cpu_busy && status.two_results))
      else $error("inconsistent queue status");
`endif

endmodule
